>>> hw/rtl/scd_pkg.sv
package scd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned VOL_W    = 7;

    // default largest accepted frame count per chunk
    localparam int unsigned MAX_CHUNK_DEF = 1024;

    localparam logic [BYTE_W-1:0] SYNC1_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC2_BYTE = 8'h55;

    // volume at or above unity passes the sample through
    localparam logic [VOL_W-1:0] VOL_UNITY = 7'd100;

    // |s| * v fits in PROD_W bits (32768 * 100 < 2**22)
    localparam int unsigned PROD_W = SAMPLE_W + VOL_W - 1;

    // floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for x < 2**PROD_W
    localparam int unsigned DIV_SHIFT   = 29;
    localparam int unsigned DIV_RECIP_W = 23;
    localparam logic [DIV_RECIP_W-1:0] DIV_RECIP = 23'd5368710;

    // quotient magnitude reaches 32768, one bit above the sample width
    localparam int unsigned QUOT_W = SAMPLE_W + 1;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = VOL_W;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_EN = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       chunk_end;
    } t_frame;

    typedef struct packed {
        logic adv_a;
        logic adv_b;
        logic adv_c;
    } t_lane_ctl;

endpackage

>>> hw/rtl/scd_parser.sv
module scd_parser #(
    parameter int unsigned MAX_CHUNK = scd_pkg::MAX_CHUNK_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [scd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                         i_stream_en,
    output logic                         o_frame_valid,
    output scd_pkg::t_frame              o_frame
);

    localparam int unsigned CntW = $clog2(MAX_CHUNK + 1);
    localparam int unsigned HdrW = 2 * scd_pkg::BYTE_W;

    localparam logic [2:0] PH_SYNC1  = 3'd0;
    localparam logic [2:0] PH_SYNC2  = 3'd1;
    localparam logic [2:0] PH_CNT_LO = 3'd2;
    localparam logic [2:0] PH_CNT_HI = 3'd3;
    localparam logic [2:0] PH_L_LO   = 3'd4;
    localparam logic [2:0] PH_L_HI   = 3'd5;
    localparam logic [2:0] PH_R_LO   = 3'd6;
    localparam logic [2:0] PH_R_HI   = 3'd7;

    logic [2:0]                  r_phase,    n_phase;
    logic [scd_pkg::BYTE_W-1:0]  r_cnt_lo,   n_cnt_lo;
    logic [CntW-1:0]             r_expected, n_expected;
    logic [CntW-1:0]             r_done,     n_done;
    logic [scd_pkg::BYTE_W-1:0]  r_left_lo,  n_left_lo;
    logic [scd_pkg::BYTE_W-1:0]  r_left_hi,  n_left_hi;
    logic [scd_pkg::BYTE_W-1:0]  r_right_lo, n_right_lo;

    logic [HdrW-1:0] count;
    logic [CntW-1:0] done_inc;
    logic            last_frame;

    assign count      = {i_rx_byte, r_cnt_lo};
    assign done_inc   = r_done + 1'b1;
    assign last_frame = !(done_inc < r_expected);

    always_comb begin
        n_phase       = r_phase;
        n_cnt_lo      = r_cnt_lo;
        n_expected    = r_expected;
        n_done        = r_done;
        n_left_lo     = r_left_lo;
        n_left_hi     = r_left_hi;
        n_right_lo    = r_right_lo;
        o_frame_valid = 1'b0;
        if (i_accept) begin
            if (!i_stream_en) begin
                n_phase = PH_SYNC1;
            end else begin
                case (r_phase)
                    PH_SYNC1: begin
                        if (i_rx_byte == scd_pkg::SYNC1_BYTE) n_phase = PH_SYNC2;
                    end
                    PH_SYNC2: begin
                        if (i_rx_byte == scd_pkg::SYNC2_BYTE) begin
                            n_phase = PH_CNT_LO;
                            n_done  = '0;
                        end else if (i_rx_byte != scd_pkg::SYNC1_BYTE) begin
                            n_phase = PH_SYNC1;
                        end
                    end
                    PH_CNT_LO: begin
                        n_cnt_lo = i_rx_byte;
                        n_phase  = PH_CNT_HI;
                    end
                    PH_CNT_HI: begin
                        n_expected = count[CntW-1:0];
                        if (count != '0 && count <= HdrW'(MAX_CHUNK)) begin
                            n_phase = PH_L_LO;
                        end else begin
                            n_phase = PH_SYNC1;
                        end
                    end
                    PH_L_LO: begin
                        n_left_lo = i_rx_byte;
                        n_phase   = PH_L_HI;
                    end
                    PH_L_HI: begin
                        n_left_hi = i_rx_byte;
                        n_phase   = PH_R_LO;
                    end
                    PH_R_LO: begin
                        n_right_lo = i_rx_byte;
                        n_phase    = PH_R_HI;
                    end
                    PH_R_HI: begin
                        o_frame_valid = 1'b1;
                        n_done        = done_inc;
                        n_phase       = last_frame ? PH_SYNC1 : PH_L_LO;
                    end
                    default: begin
                        n_phase = PH_SYNC1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_expected <= '0;
            r_done     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_expected <= n_expected;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt_lo   <= n_cnt_lo;
        r_left_lo  <= n_left_lo;
        r_left_hi  <= n_left_hi;
        r_right_lo <= n_right_lo;
    end

    assign o_frame.left      = {r_left_hi, r_left_lo};
    assign o_frame.right     = {i_rx_byte, r_right_lo};
    assign o_frame.chunk_end = last_frame;

endmodule

>>> hw/rtl/scd_scale_lane.sv
module scd_scale_lane (
    input  logic                                i_clk,
    input  scd_pkg::t_lane_ctl                  i_ctl,
    input  logic signed [scd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [scd_pkg::VOL_W-1:0]           i_volume,
    output logic signed [scd_pkg::SAMPLE_W-1:0] o_sample
);

    // wide enough to hold every quotient bit above the shift
    localparam int unsigned MulW = scd_pkg::DIV_SHIFT + scd_pkg::QUOT_W;

    logic [scd_pkg::VOL_W-1:0]    vol_eff;
    logic [scd_pkg::SAMPLE_W-1:0] mag;

    logic [scd_pkg::SAMPLE_W-1:0] r_mag_a;
    logic [scd_pkg::VOL_W-1:0]    r_vol_a;
    logic                         r_neg_a;
    logic [scd_pkg::PROD_W-1:0]   r_prod_b;
    logic                         r_neg_b;
    logic signed [scd_pkg::SAMPLE_W-1:0] r_out_c;

    logic [MulW-1:0]              recip_prod;
    logic [scd_pkg::QUOT_W-1:0]   quot;
    logic [scd_pkg::QUOT_W-1:0]   quot_signed;

    // unity and above pass through; x*100/100 is exact, so clamp to unity
    assign vol_eff = (i_volume >= scd_pkg::VOL_UNITY) ? scd_pkg::VOL_UNITY : i_volume;
    assign mag     = i_sample[scd_pkg::SAMPLE_W-1] ? (~i_sample + 1'b1) : i_sample;

    assign recip_prod  = MulW'(r_prod_b) * MulW'(scd_pkg::DIV_RECIP);
    assign quot        = recip_prod[scd_pkg::DIV_SHIFT +: scd_pkg::QUOT_W];
    assign quot_signed = r_neg_b ? (~quot + 1'b1) : quot;

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_a) begin
            r_mag_a <= mag;
            r_vol_a <= vol_eff;
            r_neg_a <= i_sample[scd_pkg::SAMPLE_W-1];
        end
        if (i_ctl.adv_b) begin
            r_prod_b <= scd_pkg::PROD_W'(r_mag_a) * scd_pkg::PROD_W'(r_vol_a);
            r_neg_b  <= r_neg_a;
        end
        if (i_ctl.adv_c) begin
            r_out_c <= quot_signed[scd_pkg::SAMPLE_W-1:0];
        end
    end

    assign o_sample = r_out_c;

endmodule

>>> hw/rtl/stereo_chunk_deframer.sv
// Byte-serial deframer for chunks of stereo 16-bit audio. Bytes enter on the
// input channel, one transaction per byte, and the block hunts for the sync
// pair 0xAA 0x55 (a repeated 0xAA keeps waiting for 0x55), then reads a
// little-endian 16-bit frame count. A count of zero or above MAX_CHUNK drops
// the header and hunting resumes. Each following group of four bytes (L low,
// L high, R low, R high) yields one output transaction carrying both samples
// scaled by the volume register (0 mutes, 100 and above pass through, other
// values give s*v/100 truncated toward zero) and chunk_end on the last frame
// of the chunk. Throughput is one byte per clock while the input is not
// stalled; after its fourth byte is accepted, a frame passes through the
// three registers of the scaling pipeline (capture and magnitude, volume
// multiply, divide by 100 via reciprocal multiply) on its way to the output.
// The input stalls only while the output is stalled and every pipeline
// stage holds a frame. Write volume (index 0) and streaming_enable (index 1)
// only while the block is idle; with streaming disabled every byte is
// consumed, resets the parser to hunting and produces nothing.
module stereo_chunk_deframer #(
    parameter int unsigned MAX_CHUNK = scd_pkg::MAX_CHUNK_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // byte input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [scd_pkg::BYTE_W-1:0]          i_rx_byte,
    // frame output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [scd_pkg::SAMPLE_W-1:0] o_left_sample,
    output logic signed [scd_pkg::SAMPLE_W-1:0] o_right_sample,
    output logic                                o_chunk_end
);

    // configuration registers
    logic [scd_pkg::VOL_W-1:0] r_volume;
    logic                      r_stream_en;

    // stage valids and chunk_end flags follow the lane pipelines
    logic r_vld_a, r_vld_b, r_vld_c;
    logic r_end_a, r_end_b, r_end_c;

    logic               rdy_a, rdy_b, rdy_c;
    logic               in_accept;
    logic               frame_valid;
    scd_pkg::t_frame    frame;
    scd_pkg::t_lane_ctl lane_ctl;

    // a stage takes new data when empty or when its contents move on
    assign rdy_c = !r_vld_c || !i_out_stall;
    assign rdy_b = !r_vld_b || rdy_c;
    assign rdy_a = !r_vld_a || rdy_b;

    assign o_in_stall = !rdy_a;
    assign in_accept  = i_in_valid && rdy_a;

    assign lane_ctl.adv_a = rdy_a;
    assign lane_ctl.adv_b = rdy_b;
    assign lane_ctl.adv_c = rdy_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_volume    <= scd_pkg::VOL_UNITY;
            r_stream_en <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scd_pkg::CFG_VOLUME:    r_volume    <= i_cfg_data[scd_pkg::VOL_W-1:0];
                scd_pkg::CFG_STREAM_EN: r_stream_en <= i_cfg_data[0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // advance the valid pipeline; hold a stage whose successor is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (rdy_a) r_vld_a <= frame_valid;
            if (rdy_b) r_vld_b <= r_vld_a;
            if (rdy_c) r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a) r_end_a <= frame.chunk_end;
        if (rdy_b) r_end_b <= r_end_a;
        if (rdy_c) r_end_c <= r_end_b;
    end

    scd_parser #(
        .MAX_CHUNK (MAX_CHUNK)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_stream_en   (r_stream_en),
        .o_frame_valid (frame_valid),
        .o_frame       (frame)
    );

    scd_scale_lane u_lane_left (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (frame.left),
        .i_volume (r_volume),
        .o_sample (o_left_sample)
    );

    scd_scale_lane u_lane_right (
        .i_clk    (i_clk),
        .i_ctl    (lane_ctl),
        .i_sample (frame.right),
        .i_volume (r_volume),
        .o_sample (o_right_sample)
    );

    assign o_out_valid = r_vld_c;
    assign o_chunk_end = r_end_c;

endmodule

>>> hw/rtl/scd_checker.sv
module scd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic signed [scd_pkg::SAMPLE_W-1:0] o_left_sample,
    input logic signed [scd_pkg::SAMPLE_W-1:0] o_right_sample,
    input logic                                o_chunk_end
);

    logic in_xact;

    assign in_xact = i_in_valid && !o_in_stall;

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_sample)
            && $stable(o_right_sample) && $stable(o_chunk_end))
        else $error("stalled output transaction changed");

    // input backpressure only comes from a stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a result appearing at an empty output must follow an accepted input byte
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(in_xact, 3))
        else $error("output transaction without matching input");

endmodule

bind stereo_chunk_deframer scd_checker u_scd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_left_sample  (o_left_sample),
    .o_right_sample (o_right_sample),
    .o_chunk_end    (o_chunk_end)
);
